FILE: design/ppo_pkg.sv
// shared types and constants for the pixel pair overlay unit
package ppo_pkg;

  localparam int DATA_W = 32;
  localparam int TERM_W = 38;

  typedef enum logic [3:0] {
    M_MAX  = 4'd0,
    M_MIN  = 4'd1,
    M_MEAN = 4'd2,
    M_SUM  = 4'd3,
    M_SUB  = 4'd4,
    M_MUL  = 4'd5,
    M_DIV  = 4'd6,
    M_AND  = 4'd7,
    M_OR   = 4'd8,
    M_COND = 4'd9
  } method_t;

  localparam logic [2:0] REG_METHOD = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_TERM0  = 3'd2;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_LT = 3'd3;
  localparam logic [2:0] CMP_GE = 3'd4;
  localparam logic [2:0] CMP_LE = 3'd5;

  localparam logic [1:0] SIDE_A = 2'd0;
  localparam logic [1:0] SIDE_B = 2'd1;

  // classified request handed from front to back
  typedef struct packed {
    logic [3:0]               method;
    logic                     cond_true;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } req_t;

  // result item
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
  } res_t;

endpackage

FILE: design/ppo_front.sv
// front end: accepts a pixel pair and evaluates the condition terms
module ppo_front #(
  parameter int MAX_TERMS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [ppo_pkg::TERM_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ppo_pkg::DATA_W-1:0] in_a_value,
  input  logic signed [ppo_pkg::DATA_W-1:0] in_b_value,
  output logic                          q_valid,
  input  logic                          q_ready,
  output ppo_pkg::req_t                 q_req
);

  logic [3:0]                 method_r;
  logic [2:0]                 count_r;
  logic [ppo_pkg::TERM_W-1:0] term_r [MAX_TERMS];
  logic [3:0]                 count_clip;
  logic                       cond;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= '0;
      count_r  <= '0;
      for (int k = 0; k < MAX_TERMS; k++) term_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ppo_pkg::REG_METHOD) method_r <= cfg_data[3:0];
      else if (cfg_index == ppo_pkg::REG_COUNT) count_r <= cfg_data[2:0];
      else begin
        for (int k = 0; k < MAX_TERMS; k++)
          if ({1'b0, cfg_index} == 4'(k) + {1'b0, ppo_pkg::REG_TERM0})
            term_r[k] <= cfg_data;
      end
    end
  end

  function automatic logic term_eval(input logic [ppo_pkg::TERM_W-1:0] t,
                                     input logic signed [31:0] a,
                                     input logic signed [31:0] b);
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic               r;
    rhs = t[31:0];
    if (t[36:35] == ppo_pkg::SIDE_A) lhs = a;
    else if (t[36:35] == ppo_pkg::SIDE_B) lhs = b;
    else lhs = '0;
    unique case (t[34:32])
      ppo_pkg::CMP_EQ: r = (lhs == rhs);
      ppo_pkg::CMP_NE: r = (lhs != rhs);
      ppo_pkg::CMP_GT: r = (lhs > rhs);
      ppo_pkg::CMP_LT: r = (lhs < rhs);
      ppo_pkg::CMP_GE: r = (lhs >= rhs);
      ppo_pkg::CMP_LE: r = (lhs <= rhs);
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

  // left to right term chain
  assign count_clip = ({1'b0, count_r} > 4'(MAX_TERMS)) ? 4'(MAX_TERMS) : {1'b0, count_r};

  always_comb begin
    cond = 1'b1;
    for (int k = 0; k < MAX_TERMS; k++) begin
      if (4'(k) < count_clip) begin
        if (k == 0) cond = term_eval(term_r[k], in_a_value, in_b_value);
        else if (term_r[k][37]) cond = cond | term_eval(term_r[k], in_a_value, in_b_value);
        else cond = cond & term_eval(term_r[k], in_a_value, in_b_value);
      end
    end
  end

  // request register
  logic          valid_r;
  ppo_pkg::req_t req_r;
  assign in_ready = !valid_r || q_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (in_ready) valid_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.method    <= method_r;
      req_r.cond_true <= cond;
      req_r.a         <= in_a_value;
      req_r.b         <= in_b_value;
    end
  end
  assign q_valid = valid_r;
  assign q_req   = req_r;

endmodule

FILE: design/ppo_fifo.sv
// small request queue between front and back
module ppo_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/ppo_div.sv
// pipelined restoring divider, one quotient bit per stage
module ppo_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] q_r   [1:NUM_W];
  logic [DEN_W:0]   rem_r [1:NUM_W];
  logic [DEN_W-1:0] d_r   [1:NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [NUM_W-1:0] q_in;
    logic [DEN_W:0]   rem_in;
    logic [DEN_W-1:0] d_in;
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] diff;
    // stage operands: the request itself for the first stage
    if (s == 0) begin : g_first
      assign q_in   = num;
      assign rem_in = '0;
      assign d_in   = den;
    end else begin : g_next
      assign q_in   = q_r[s];
      assign rem_in = rem_r[s];
      assign d_in   = d_r[s];
    end
    assign sh   = {rem_in, q_in[NUM_W-1]};
    assign diff = sh - {2'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s+1] <= d_in;
        if (!diff[DEN_W+1]) begin
          rem_r[s+1] <= diff[DEN_W:0];
          q_r[s+1]   <= {q_in[NUM_W-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= sh[DEN_W:0];
          q_r[s+1]   <= {q_in[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[NUM_W];

endmodule

FILE: design/ppo_back.sv
// back end: arithmetic pipeline with stall-together enable and output register
module ppo_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  ppo_pkg::req_t q_req,
  output logic          out_valid,
  input  logic          out_ready,
  output ppo_pkg::res_t out_res
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int DEPTH = NUM_W + 1;

  typedef struct packed {
    logic [3:0]  method;
    logic [31:0] value;
    logic        sat;
    logic        neg;
    logic        zero;
  } tag_t;

  logic        en;
  logic [DEPTH-1:0] v_r;
  tag_t        tag_r [DEPTH];
  tag_t        tag0;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_pipe_r [DEPTH-1];
  logic [NUM_W-1:0] quo;
  logic [31:0] absb;
  logic [NUM_W-1:0] absn;
  logic signed [32:0] s33, d33;
  logic        last_v;
  tag_t        last_t;

  // output register
  ppo_pkg::res_t fin;
  ppo_pkg::res_t ob_r;
  logic          ob_v_r;

  assign en      = !ob_v_r || out_ready;
  assign q_ready = en;

  // stage 0 classification of simple methods
  always_comb begin
    s33 = 33'(q_req.a) + 33'(q_req.b);
    d33 = 33'(q_req.a) - 33'(q_req.b);
    tag0.method = q_req.method;
    tag0.sat    = 1'b0;
    tag0.neg    = q_req.a[31] ^ q_req.b[31];
    tag0.zero   = (q_req.b == '0);
    unique case (q_req.method)
      ppo_pkg::M_MAX:  tag0.value = (q_req.a > q_req.b) ? q_req.a : q_req.b;
      ppo_pkg::M_MIN:  tag0.value = (q_req.a < q_req.b) ? q_req.a : q_req.b;
      ppo_pkg::M_MEAN: tag0.value = s33[32:1];
      ppo_pkg::M_SUM: begin
        tag0.sat   = s33[32] != s33[31];
        tag0.value = tag0.sat ? (s33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s33[31:0];
      end
      ppo_pkg::M_SUB: begin
        tag0.sat   = d33[32] != d33[31];
        tag0.value = tag0.sat ? (d33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : d33[31:0];
      end
      ppo_pkg::M_AND:
        tag0.value = (q_req.a > 0 && q_req.b > 0) ? 32'(1 << FRAC_BITS) : '0;
      ppo_pkg::M_OR:
        tag0.value = (q_req.a > 0 || q_req.b > 0) ? 32'(1 << FRAC_BITS) : '0;
      ppo_pkg::M_COND:
        tag0.value = q_req.cond_true ? 32'(1 << FRAC_BITS) : '0;
      default: tag0.value = q_req.a;
    endcase
  end

  // divider operands as magnitudes
  assign absb = q_req.b[31] ? 32'(-q_req.b) : q_req.b;
  assign absn = q_req.a[31] ? NUM_W'(-(NUM_W'(q_req.a) <<< FRAC_BITS))
                            : (NUM_W'(q_req.a) << FRAC_BITS);

  ppo_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
    .clk(clk), .en(en), .num(absn), .den(absb), .quo(quo)
  );

  // tag pipeline alongside the divider
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[DEPTH-2:0], q_valid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag0;
      for (int k = 1; k < DEPTH; k++) tag_r[k] <= tag_r[k-1];
      prod_r <= 64'(q_req.a) * 64'(q_req.b);
      prod_pipe_r[0] <= prod_r;
      for (int k = 1; k < DEPTH-1; k++) prod_pipe_r[k] <= prod_pipe_r[k-1];
    end
  end

  // divider result is ready one stage before the tail; register it
  logic [NUM_W-1:0] quo_r;
  always_ff @(posedge clk) if (en) quo_r <= quo;

  // final select
  logic signed [63:0] psh;
  logic signed [NUM_W:0] qs;
  assign last_v = v_r[DEPTH-1];
  assign last_t = tag_r[DEPTH-1];
  assign psh    = prod_pipe_r[DEPTH-2] >>> FRAC_BITS;
  assign qs     = last_t.neg ? -(NUM_W+1)'(quo_r) : (NUM_W+1)'(quo_r);
  always_comb begin
    fin.value = last_t.value;
    fin.sat   = last_t.sat;
    if (last_t.method == ppo_pkg::M_MUL) begin
      if (psh > 64'sh7FFF_FFFF) begin
        fin.value = 32'h7FFF_FFFF; fin.sat = 1'b1;
      end else if (psh < -64'sh8000_0000) begin
        fin.value = 32'h8000_0000; fin.sat = 1'b1;
      end else fin.value = psh[31:0];
    end else if (last_t.method == ppo_pkg::M_DIV) begin
      if (last_t.zero) fin.value = '0;
      else if (qs > (NUM_W+1)'(33'sh0_7FFF_FFFF)) begin
        fin.value = 32'h7FFF_FFFF; fin.sat = 1'b1;
      end else if (qs < -(NUM_W+1)'(33'sh0_8000_0000)) begin
        fin.value = 32'h8000_0000; fin.sat = 1'b1;
      end else fin.value = qs[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ob_v_r <= 1'b0;
    else if (en) ob_v_r <= last_v;
  end
  always_ff @(posedge clk) if (en) ob_r <= fin;

  assign out_valid = ob_v_r;
  assign out_res   = ob_r;

endmodule

FILE: design/pixel_pair_overlay_alu.sv
// Pixel pair overlay unit: one (A, B) pair of signed Q16.16 values per cycle
// is accepted unless the unit stalls, and one result per pair leaves in
// order. Every method runs through the same fixed pipeline: a front stage
// evaluates the condition terms, a two-entry queue decouples it from the
// back end, and the back end is as long as the pipelined divider (32 +
// FRAC_BITS stages plus two). While results are taken the rate is one pair
// per cycle; the whole back end stalls together when the result is not taken.
module pixel_pair_overlay_alu #(
  parameter int MAX_TERMS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [37:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_a_value,
  input  logic signed [31:0] in_b_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_result_value,
  output logic        out_saturated
);

  localparam int REQ_W = $bits(ppo_pkg::req_t);

  logic          f_valid, f_ready, b_valid, b_ready;
  ppo_pkg::req_t f_req, b_req;
  ppo_pkg::res_t res;

  ppo_front #(.MAX_TERMS(MAX_TERMS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_a_value, .in_b_value,
    .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
  );

  ppo_fifo #(.W(REQ_W)) u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
  );

  ppo_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_result_value = res.value;
  assign out_saturated    = res.sat;

endmodule

FILE: design/ppo_checker.sv
// port-level checks for the overlay unit
module ppo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic        out_saturated
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result changed while stalled");

  // saturation only on a clipped bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_result_value == 32'h7FFF_FFFF || out_result_value == 32'h8000_0000)
    else $error("saturated flag without clipped value");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // in_valid, in_ready and out_valid always known outside reset
  a_hs_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, in_ready, out_valid}))
    else $error("unknown handshake level");

endmodule

bind pixel_pair_overlay_alu ppo_checker u_ppo_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_result_value, .out_saturated
);

FILE: test/tb_top.sv
// testbench for the pixel pair overlay unit
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC = 16;
  localparam int NTERMS = 4;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] CMP_BAD6 = 3'd6;
  localparam logic [2:0] CMP_BAD7 = 3'd7;
  localparam logic [1:0] SIDE_ZERO = 2'd2;
  localparam logic [1:0] SIDE_ZERO3 = 2'd3;
  localparam logic JOIN_AND = 1'b0;
  localparam logic JOIN_OR = 1'b1;
  localparam logic [3:0] M_PASS_LO = 4'd10;
  localparam logic [3:0] M_PASS_HI = 4'd15;
  localparam logic [2:0] REG_TERM3 = 3'd5;
  localparam logic [2:0] REG_BAD6 = 3'd6;
  localparam logic [2:0] REG_BAD7 = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } overlay_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [37:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic signed [31:0] in_a_value;
  logic signed [31:0] in_b_value;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_result_value;
  logic        out_saturated;

  // shadow of the configuration
  logic [3:0]  cur_method;
  logic [2:0]  cur_count;
  logic [37:0] cur_terms [NTERMS];

  overlay_res_t expected_q[$];
  int  errors;
  int  idle_cycles;
  bit  idle_enable;
  bit  stim_done;

  pixel_pair_overlay_alu uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_value(in_a_value), .in_b_value(in_b_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_saturated(out_saturated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate a wide value to 32 bits
  function automatic overlay_res_t clip32(input logic signed [95:0] v);
    overlay_res_t r;
    r.sat = 1'b0;
    if (v > 96'sh7FFFFFFF) begin
      r.value = 32'h7FFFFFFF;
      r.sat = 1'b1;
    end else if (v < -96'sh80000000) begin
      r.value = 32'h80000000;
      r.sat = 1'b1;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

  // one comparison term
  function automatic bit term_holds(input logic [37:0] t,
                                    input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    rhs = t[31:0];
    case (t[36:35])
      ppo_pkg::SIDE_A: lhs = a;
      ppo_pkg::SIDE_B: lhs = b;
      default: lhs = '0;
    endcase
    case (t[34:32])
      ppo_pkg::CMP_EQ: return lhs == rhs;
      ppo_pkg::CMP_NE: return lhs != rhs;
      ppo_pkg::CMP_GT: return lhs > rhs;
      ppo_pkg::CMP_LT: return lhs < rhs;
      ppo_pkg::CMP_GE: return lhs >= rhs;
      ppo_pkg::CMP_LE: return lhs <= rhs;
      default: return 1'b0;
    endcase
  endfunction

  // expected overlay result for one pixel pair
  function automatic overlay_res_t overlay_of(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    overlay_res_t r;
    logic signed [95:0] wa;
    logic signed [95:0] wb;
    logic signed [95:0] wide;
    int n;
    bit acc;
    wa = a;
    wb = b;
    r = '0;
    case (cur_method)
      ppo_pkg::M_MAX: r.value = (a > b) ? a : b;
      ppo_pkg::M_MIN: r.value = (a < b) ? a : b;
      ppo_pkg::M_MEAN: begin
        wide = (wa + wb) >>> 1;
        r.value = wide[31:0];
      end
      ppo_pkg::M_SUM: r = clip32(wa + wb);
      ppo_pkg::M_SUB: r = clip32(wa - wb);
      ppo_pkg::M_MUL: r = clip32((wa * wb) >>> FRAC);
      ppo_pkg::M_DIV: begin
        if (b != 0) r = clip32((wa <<< FRAC) / wb);
      end
      ppo_pkg::M_AND: r.value = (a > 0 && b > 0) ? (32'd1 << FRAC) : 32'd0;
      ppo_pkg::M_OR: r.value = (a > 0 || b > 0) ? (32'd1 << FRAC) : 32'd0;
      ppo_pkg::M_COND: begin
        n = (cur_count > NTERMS) ? NTERMS : cur_count;
        acc = 1'b1;
        if (n > 0) acc = term_holds(cur_terms[0], a, b);
        for (int k = 1; k < n; k++) begin
          if (cur_terms[k][37] == JOIN_OR) acc = acc | term_holds(cur_terms[k], a, b);
          else acc = acc & term_holds(cur_terms[k], a, b);
        end
        r.value = acc ? (32'd1 << FRAC) : 32'd0;
      end
      default: r.value = a;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // random idle burst on the input, when idles are enabled
  task automatic maybe_idle(input int pct);
    if (idle_enable && $urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // send one request and record its expected result
  task automatic send_pair(input logic signed [31:0] a, input logic signed [31:0] b);
    maybe_idle(8);
    in_valid <= 1'b1;
    in_a_value <= a;
    in_b_value <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q = {expected_q, overlay_of(a, b)};
  endtask

  // register write, only when idle
  task automatic write_reg(input logic [2:0] idx, input logic [37:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ppo_pkg::REG_METHOD: cur_method = val[3:0];
      ppo_pkg::REG_COUNT: cur_count = val[2:0];
      REG_BAD6, REG_BAD7: ;
      default: cur_terms[idx - ppo_pkg::REG_TERM0] = val;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [37:0] make_term(input logic join_or, input logic [1:0] side,
                                            input logic [2:0] cmp,
                                            input logic [31:0] rhs);
    return {join_or, side, cmp, rhs};
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(6) - 3;
      3: return ($urandom_range(8) - 4) << FRAC;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [37:0] rand_term();
    logic [37:0] t;
    t = 38'({$urandom, $urandom});
    if ($urandom_range(1)) t[31:0] = rand_value();
    return t;
  endfunction

  // directed extremes, every method, condition corner cases
  task automatic test_directed();
    logic signed [31:0] vals[6];
    vals = '{32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh00010000, -32'sh00010000, 1};
    for (int m = 0; m <= M_PASS_HI; m++) begin
      wait_idle();
      write_reg(ppo_pkg::REG_METHOD, 38'(m));
      if (m == ppo_pkg::M_COND || m == ppo_pkg::M_DIV || m == ppo_pkg::M_MUL ||
          m == ppo_pkg::M_SUM)
        foreach (vals[i]) send_pair(vals[i], vals[(i + 1) % 6]);
      else begin
        send_pair(vals[0], vals[1]);
        send_pair(vals[4], vals[2]);
      end
    end
    // condition: no terms, count beyond max, bad codes, zero side code 3
    wait_idle();
    write_reg(ppo_pkg::REG_METHOD, 38'(ppo_pkg::M_COND));
    write_reg(ppo_pkg::REG_COUNT, 38'(0));
    send_pair(5, 5);
    wait_idle();
    write_reg(ppo_pkg::REG_TERM0, make_term(JOIN_AND, ppo_pkg::SIDE_A, ppo_pkg::CMP_EQ, 32'd5));
    write_reg(3'(ppo_pkg::REG_TERM0 + 1), make_term(JOIN_OR, SIDE_ZERO3, CMP_BAD6, 32'd0));
    write_reg(3'(ppo_pkg::REG_TERM0 + 2),
              make_term(JOIN_AND, SIDE_ZERO, ppo_pkg::CMP_LE, 32'd0));
    write_reg(REG_TERM3, make_term(JOIN_OR, ppo_pkg::SIDE_B, CMP_BAD7, 32'hFFFFFFFF));
    write_reg(REG_BAD6, '1);
    write_reg(ppo_pkg::REG_COUNT, 38'(7));
    send_pair(5, 0);
    send_pair(4, 0);
  endtask

  // random phases through many settings
  task automatic test_random(input int items);
    int left;
    left = items;
    while (left > 0) begin
      wait_idle();
      write_reg(ppo_pkg::REG_METHOD, 38'(($urandom_range(9) == 0) ?
                $urandom_range(M_PASS_HI, M_PASS_LO) : $urandom_range(9)));
      if (cur_method == ppo_pkg::M_COND || $urandom_range(3) == 0) begin
        write_reg(ppo_pkg::REG_COUNT, 38'($urandom_range(7)));
        for (int k = 0; k < NTERMS; k++) write_reg(3'(ppo_pkg::REG_TERM0 + k), rand_term());
      end
      repeat ($urandom_range(60, 20)) begin
        if (left > 0) begin
          send_pair(rand_value(), rand_value());
          left--;
        end
      end
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    overlay_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result");
      else begin
        want = expected_q.pop_front();
        if (out_result_value !== want.value)
          report_mismatch($sformatf("value %h want %h", out_result_value, want.value));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("saturated %b want %b", out_saturated, want.sat));
      end
    end
    if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(99) < 6) begin
      idle_cycles <= $urandom_range(15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted request or result
  int quiet;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("pixel_pair_overlay_alu test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_a_value = '0;
    in_b_value = '0;
    out_ready = 1'b0;
    idle_cycles = 0;
    errors = 0;
    quiet = 0;
    stim_done = 1'b0;
    idle_enable = 1'b1;
    cur_method = '0;
    cur_count = '0;
    foreach (cur_terms[k]) cur_terms[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(850);
    idle_enable = 1'b0;
    test_random(180);
    stim_done = 1'b0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("pixel_pair_overlay_alu test passed");
    else $display("pixel_pair_overlay_alu test failed");
    $finish;
  end

endmodule
